/* hdl/ivau_pkg.sv */
// Shared types and codes of the interrupt vector allocator.
package ivau_pkg;

  // Action codes carried by an input beat.
  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_FREE    = 3'd1,
    ACT_ROUTE   = 3'd2,
    ACT_UNROUTE = 3'd3,
    ACT_RAISE   = 3'd4
  } ivau_action_t;

  // Status codes returned with each result beat.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_NONE_FREE = 3'd3,
    ST_IGNORED   = 3'd4
  } ivau_status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } ivau_state_t;

  // Write commands to the descriptor store.
  typedef struct packed {
    logic route;    // store handler id and flags, clear count, mark routed
    logic unroute;  // drop the handler id only
    logic bump;     // write back the incremented event count
  } ivau_desc_wr_t;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned VEC_W     = 8;
  localparam int unsigned HID_W     = 16;
  localparam int unsigned DATA_W    = 32;

endpackage

/* hdl/ivau_ffz.sv */
// Find-first-zero encoder over one 32-bit word of the allocation map.
module ivau_ffz (
  input  logic [ivau_pkg::WORD_BITS-1:0] word,
  output logic                           found,
  output logic [ivau_pkg::POS_W-1:0]     pos
);

  logic [ivau_pkg::WORD_BITS-1:0] inv;
  logic [ivau_pkg::WORD_BITS-1:0] lowest;

  // Isolate the lowest free bit as a one-hot word.
  assign inv    = ~word;
  assign lowest = inv & (~inv + ivau_pkg::WORD_BITS'(1));
  assign found  = |inv;

  // Encode the one-hot position; each output bit is an independent OR.
  always_comb begin
    pos = '0;
    for (int i = 0; i < ivau_pkg::WORD_BITS; i++) begin
      if (lowest[i]) begin
        pos = pos | ivau_pkg::POS_W'(i);
      end
    end
  end

endmodule

/* hdl/ivau_desc_mem.sv */
// Per-vector descriptor store: handler id with routed bits, flags and event count.
module ivau_desc_mem #(
  parameter int NUM_VECTORS = 96
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(NUM_VECTORS)-1:0]  rd_addr,
  input  logic [$clog2(NUM_VECTORS)-1:0]  wr_addr,
  input  ivau_pkg::ivau_desc_wr_t         wr_cmd,
  input  logic [ivau_pkg::HID_W-1:0]      wr_hid,
  input  logic [ivau_pkg::DATA_W-1:0]     wr_flags,
  input  logic [ivau_pkg::DATA_W-1:0]     wr_count,
  output logic [ivau_pkg::HID_W-1:0]      hid_q,
  output logic [ivau_pkg::DATA_W-1:0]     flags_q,
  output logic [ivau_pkg::DATA_W-1:0]     count_q
);

  logic [ivau_pkg::HID_W-1:0]  hid_mem   [NUM_VECTORS];
  logic [ivau_pkg::DATA_W-1:0] flags_mem [NUM_VECTORS];
  logic [ivau_pkg::DATA_W-1:0] count_mem [NUM_VECTORS];
  logic [NUM_VECTORS-1:0]      routed_r;
  logic                        routed_q_r;
  logic [ivau_pkg::HID_W-1:0]  hid_q_r;
  logic [ivau_pkg::DATA_W-1:0] flags_q_r;
  logic [ivau_pkg::DATA_W-1:0] count_q_r;

  // Routed bits stand in for a cleared handler table after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      routed_r <= '0;
    end else if (wr_cmd.route) begin
      routed_r[wr_addr] <= 1'b1;
    end else if (wr_cmd.unroute) begin
      routed_r[wr_addr] <= 1'b0;
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (wr_cmd.route) begin
      hid_mem[wr_addr]   <= wr_hid;
      flags_mem[wr_addr] <= wr_flags;
      count_mem[wr_addr] <= '0;
    end else if (wr_cmd.bump) begin
      count_mem[wr_addr] <= wr_count;
    end
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    routed_q_r <= routed_r[rd_addr];
    hid_q_r    <= hid_mem[rd_addr];
    flags_q_r  <= flags_mem[rd_addr];
    count_q_r  <= count_mem[rd_addr];
  end

  // An unrouted vector reads as handler id zero.
  assign hid_q   = routed_q_r ? hid_q_r : '0;
  assign flags_q = flags_q_r;
  assign count_q = count_q_r;

endmodule

/* hdl/interrupt_vector_allocator_unit.sv */
// Top level of the interrupt vector allocator: sequencer, allocation map and result register.
//
// Free, route, unroute and raise read the descriptor of the vector from memory on
// the accepting edge and update it at the end of the next cycle. Allocate steps
// the shared find-first-zero encoder through the 32-bit words of the allocation
// map in order until it finds a free bit or has examined the last word.
// busy is high while an item is at work. Each result is shown for exactly one
// cycle on the out_ ports with out_valid high, in the cycle after the item
// finishes; busy is already low in that cycle, so the next item may be started
// while the result is on the ports. The receiver must take every result when it
// appears. The handler table resets to empty at once through per-vector routed
// bits; no clearing pass is needed after reset.
module interrupt_vector_allocator_unit #(
  parameter int NUM_VECTORS  = 96,
  parameter int FIRST_VECTOR = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_action,
  input  logic [ivau_pkg::VEC_W-1:0]    in_vector,
  input  logic [ivau_pkg::HID_W-1:0]    in_handler_id,
  input  logic [ivau_pkg::DATA_W-1:0]   in_route_flags,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [ivau_pkg::VEC_W-1:0]    out_vector_out,
  output logic                          out_dispatch,
  output logic [ivau_pkg::HID_W-1:0]    out_handler_out,
  output logic [ivau_pkg::DATA_W-1:0]   out_flags_out,
  output logic [ivau_pkg::DATA_W-1:0]   out_event_count
);

  localparam int IDX_W     = $clog2(NUM_VECTORS);
  localparam int MAP_WORDS = (NUM_VECTORS + 31) / 32;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [ivau_pkg::VEC_W-1:0] FIRST_V = ivau_pkg::VEC_W'(FIRST_VECTOR);

  ivau_pkg::ivau_state_t        state_r, state_nxt;
  logic [2:0]                   action_r, action_nxt;
  logic [ivau_pkg::VEC_W-1:0]   vector_r, vector_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic                         in_range_r, in_range_nxt;
  logic [ivau_pkg::HID_W-1:0]   hid_r, hid_nxt;
  logic [ivau_pkg::DATA_W-1:0]  flags_r, flags_nxt;
  logic [WORD_W-1:0]            word_r, word_nxt;
  logic [NUM_VECTORS-1:0]       map_r, map_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [2:0]                   status_r, status_nxt;
  logic [ivau_pkg::VEC_W-1:0]   vout_r, vout_nxt;
  logic                         disp_r, disp_nxt;
  logic [ivau_pkg::HID_W-1:0]   hout_r, hout_nxt;
  logic [ivau_pkg::DATA_W-1:0]  fout_r, fout_nxt;
  logic [ivau_pkg::DATA_W-1:0]  cnt_r, cnt_nxt;

  logic                         accept;
  logic [ivau_pkg::VEC_W-1:0]   in_idx;
  logic                         in_in_range;
  logic [IDX_W-1:0]             rd_addr;
  logic [MAP_WORDS*32-1:0]      map_pad;
  logic [ivau_pkg::WORD_BITS-1:0] scan_word;
  logic                         scan_found;
  logic [ivau_pkg::POS_W-1:0]   scan_pos;
  logic [IDX_W-1:0]             alloc_idx;
  logic [ivau_pkg::VEC_W-1:0]   alloc_vec;
  ivau_pkg::ivau_desc_wr_t      desc_wr;
  logic [ivau_pkg::HID_W-1:0]   desc_hid;
  logic [ivau_pkg::DATA_W-1:0]  desc_flags;
  logic [ivau_pkg::DATA_W-1:0]  desc_count;
  logic [ivau_pkg::DATA_W-1:0]  count_inc;

  // Input handshake and vector index of the incoming beat.
  assign accept      = start && (state_r == ivau_pkg::S_IDLE);
  assign busy        = (state_r != ivau_pkg::S_IDLE);
  assign in_idx      = in_vector - FIRST_V;
  assign in_in_range = ({1'b0, in_idx} < 9'(NUM_VECTORS));
  assign rd_addr     = in_in_range ? in_idx[IDX_W-1:0] : '0;

  // Map view for the scan; bits past the last vector count as taken.
  always_comb begin
    map_pad = '1;
    map_pad[NUM_VECTORS-1:0] = map_r;
  end

  assign scan_word = map_pad[{word_r, 5'b0} +: 32];

  ivau_ffz u_ffz (
    .word  (scan_word),
    .found (scan_found),
    .pos   (scan_pos)
  );

  assign alloc_idx = IDX_W'({word_r, scan_pos});
  assign alloc_vec = ivau_pkg::VEC_W'(int'({word_r, scan_pos}) + FIRST_VECTOR);
  assign count_inc = desc_count + ivau_pkg::DATA_W'(1);

  ivau_desc_mem #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_desc (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .wr_addr  (idx_r),
    .wr_cmd   (desc_wr),
    .wr_hid   (hid_r),
    .wr_flags (flags_r),
    .wr_count (count_inc),
    .hid_q    (desc_hid),
    .flags_q  (desc_flags),
    .count_q  (desc_count)
  );

  // Sequencer: next state, map update, descriptor writes and result.
  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    vector_nxt    = vector_r;
    idx_nxt       = idx_r;
    in_range_nxt  = in_range_r;
    hid_nxt       = hid_r;
    flags_nxt     = flags_r;
    word_nxt      = word_r;
    map_nxt       = map_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    vout_nxt      = vout_r;
    disp_nxt      = disp_r;
    hout_nxt      = hout_r;
    fout_nxt      = fout_r;
    cnt_nxt       = cnt_r;
    desc_wr       = '0;

    case (state_r)
      ivau_pkg::S_IDLE: begin
        if (accept) begin
          action_nxt   = in_action;
          vector_nxt   = in_vector;
          idx_nxt      = in_idx[IDX_W-1:0];
          in_range_nxt = in_in_range;
          hid_nxt      = in_handler_id;
          flags_nxt    = in_route_flags;
          word_nxt     = '0;
          if (in_action == ivau_pkg::ACT_ALLOC) begin
            state_nxt = ivau_pkg::S_SCAN;
          end else begin
            state_nxt = ivau_pkg::S_EXEC;
          end
        end
      end

      ivau_pkg::S_SCAN: begin
        // One map word per cycle through the shared encoder.
        disp_nxt = 1'b0;
        hout_nxt = '0;
        fout_nxt = '0;
        cnt_nxt  = '0;
        if (scan_found) begin
          map_nxt[alloc_idx] = 1'b1;
          status_nxt    = ivau_pkg::ST_OK;
          vout_nxt      = alloc_vec;
          out_valid_nxt = 1'b1;
          state_nxt     = ivau_pkg::S_IDLE;
        end else if (word_r == WORD_W'(MAP_WORDS - 1)) begin
          status_nxt    = ivau_pkg::ST_NONE_FREE;
          vout_nxt      = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ivau_pkg::S_IDLE;
        end else begin
          word_nxt = word_r + WORD_W'(1);
        end
      end

      ivau_pkg::S_EXEC: begin
        // Descriptor data of the vector is valid now.
        out_valid_nxt = 1'b1;
        state_nxt     = ivau_pkg::S_IDLE;
        vout_nxt      = vector_r;
        status_nxt    = ivau_pkg::ST_IGNORED;
        disp_nxt      = 1'b0;
        hout_nxt      = '0;
        fout_nxt      = '0;
        cnt_nxt       = '0;
        case (action_r)
          ivau_pkg::ACT_FREE: begin
            if (in_range_r) begin
              map_nxt[idx_r] = 1'b0;
              status_nxt     = ivau_pkg::ST_OK;
            end
          end
          ivau_pkg::ACT_ROUTE: begin
            if (!in_range_r) begin
              status_nxt = ivau_pkg::ST_INVALID;
            end else if (desc_hid != '0) begin
              status_nxt = ivau_pkg::ST_BUSY;
            end else begin
              map_nxt[idx_r] = 1'b1;
              desc_wr.route  = 1'b1;
              status_nxt     = ivau_pkg::ST_OK;
            end
          end
          ivau_pkg::ACT_UNROUTE: begin
            if (!in_range_r) begin
              status_nxt = ivau_pkg::ST_INVALID;
            end else begin
              desc_wr.unroute = 1'b1;
              status_nxt      = ivau_pkg::ST_OK;
            end
          end
          ivau_pkg::ACT_RAISE: begin
            if (!in_range_r) begin
              status_nxt = ivau_pkg::ST_INVALID;
            end else if (desc_hid != '0) begin
              desc_wr.bump = 1'b1;
              status_nxt   = ivau_pkg::ST_OK;
              disp_nxt     = 1'b1;
              hout_nxt     = desc_hid;
              fout_nxt     = desc_flags;
              cnt_nxt      = count_inc;
            end
          end
          default: begin
            status_nxt = ivau_pkg::ST_IGNORED;
          end
        endcase
      end

      default: begin
        state_nxt = ivau_pkg::S_IDLE;
      end
    endcase
  end

  // Control state and the allocation map.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ivau_pkg::S_IDLE;
      map_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_r       <= map_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    action_r   <= action_nxt;
    vector_r   <= vector_nxt;
    idx_r      <= idx_nxt;
    in_range_r <= in_range_nxt;
    hid_r      <= hid_nxt;
    flags_r    <= flags_nxt;
    word_r     <= word_nxt;
    status_r   <= status_nxt;
    vout_r     <= vout_nxt;
    disp_r     <= disp_nxt;
    hout_r     <= hout_nxt;
    fout_r     <= fout_nxt;
    cnt_r      <= cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_vector_out  = vout_r;
  assign out_dispatch    = disp_r;
  assign out_handler_out = hout_r;
  assign out_flags_out   = fout_r;
  assign out_event_count = cnt_r;

endmodule

/* hdl/ivau_checker.sv */
// Port-level assertions for the interrupt vector allocator, bound to the top level.
module ivau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [7:0]  out_vector_out,
  input logic        out_dispatch,
  input logic [15:0] out_handler_out,
  input logic [31:0] out_flags_out,
  input logic [31:0] out_event_count
);

  // An accepted beat keeps the block busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // Every item passes through a scan or execute state before its result, so result strobes never abut.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  // A dispatch always reports success.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dispatch) |-> (out_status == ivau_pkg::ST_OK))
    else $error("dispatch with a failing status");

  // Without a dispatch the descriptor fields are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_dispatch) |->
      (out_handler_out == '0 && out_flags_out == '0 && out_event_count == '0))
    else $error("descriptor fields set without a dispatch");

  // A full map returns vector zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ivau_pkg::ST_NONE_FREE) |-> (out_vector_out == 8'd0))
    else $error("none free reported with a nonzero vector");

endmodule

bind interrupt_vector_allocator_unit ivau_checker u_ivau_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_vector_out  (out_vector_out),
  .out_dispatch    (out_dispatch),
  .out_handler_out (out_handler_out),
  .out_flags_out   (out_flags_out),
  .out_event_count (out_event_count)
);

/* tb/sv/interrupt_vector_allocator_unit_tb.sv */
// Self-checking testbench for the interrupt vector allocator with a built-in predictor.
`timescale 1ns / 100ps

module interrupt_vector_allocator_unit_tb;

  localparam int NUM_VEC   = 96;
  localparam int BASE_VEC  = 32;
  localparam int IDX_W     = $clog2(NUM_VEC);
  localparam int STALL_MAX = 2000;
  localparam int RAND_BEATS = 450;

  // Action codes beyond the defined set; the block must ignore them.
  localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;

  // One command beat as it goes onto the input ports.
  typedef struct packed {
    logic [2:0]                  action;
    logic [ivau_pkg::VEC_W-1:0]  vector;
    logic [ivau_pkg::HID_W-1:0]  handler;
    logic [ivau_pkg::DATA_W-1:0] flags;
  } vec_cmd_t;

  // One result beat as the block should present it.
  typedef struct packed {
    ivau_pkg::ivau_status_t      status;
    logic [ivau_pkg::VEC_W-1:0]  vector;
    logic                        dispatch;
    logic [ivau_pkg::HID_W-1:0]  handler;
    logic [ivau_pkg::DATA_W-1:0] flags;
    logic [ivau_pkg::DATA_W-1:0] events;
  } vec_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [2:0]                  in_action = '0;
  logic [ivau_pkg::VEC_W-1:0]  in_vector = '0;
  logic [ivau_pkg::HID_W-1:0]  in_handler_id = '0;
  logic [ivau_pkg::DATA_W-1:0] in_route_flags = '0;
  logic                        out_valid;
  logic [2:0]                  out_status;
  logic [ivau_pkg::VEC_W-1:0]  out_vector_out;
  logic                        out_dispatch;
  logic [ivau_pkg::HID_W-1:0]  out_handler_out;
  logic [ivau_pkg::DATA_W-1:0] out_flags_out;
  logic [ivau_pkg::DATA_W-1:0] out_event_count;

  // Mirror of the allocator state.
  logic [NUM_VEC-1:0]          vec_in_use;
  logic [ivau_pkg::HID_W-1:0]  handler_of [NUM_VEC];
  logic [ivau_pkg::DATA_W-1:0] flags_of [NUM_VEC];
  logic [ivau_pkg::DATA_W-1:0] events_of [NUM_VEC];

  vec_cmd_t    cmd_q[$];
  vec_result_t outcome_q[$];
  vec_cmd_t    cur_cmd;

  int planned_cmds = 0;
  int cmds_taken = 0;
  int results_seen = 0;
  int dispatches_seen = 0;
  int full_allocs_seen = 0;
  int errors = 0;
  int stall_cycles = 0;

  interrupt_vector_allocator_unit #(
    .NUM_VECTORS  (NUM_VEC),
    .FIRST_VECTOR (BASE_VEC)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_vector       (in_vector),
    .in_handler_id   (in_handler_id),
    .in_route_flags  (in_route_flags),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_vector_out  (out_vector_out),
    .out_dispatch    (out_dispatch),
    .out_handler_out (out_handler_out),
    .out_flags_out   (out_flags_out),
    .out_event_count (out_event_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one command to the mirrored state and return the result it should give.
  function automatic vec_result_t resolve_action(input vec_cmd_t c);
    vec_result_t r;
    logic [ivau_pkg::VEC_W-1:0] idx;
    logic [IDX_W-1:0] slot;
    logic in_range;
    logic found;
    r = '0;
    r.status = ivau_pkg::ST_IGNORED;
    r.vector = c.vector;
    idx = c.vector - ivau_pkg::VEC_W'(BASE_VEC);
    in_range = (idx < NUM_VEC);
    slot = idx[IDX_W-1:0];
    found = 1'b0;
    case (c.action)
      ivau_pkg::ACT_ALLOC: begin
        r.status = ivau_pkg::ST_NONE_FREE;
        r.vector = '0;
        for (int i = 0; i < NUM_VEC; i++) begin
          if (!found && !vec_in_use[i]) begin
            found = 1'b1;
            vec_in_use[i] = 1'b1;
            r.status = ivau_pkg::ST_OK;
            r.vector = ivau_pkg::VEC_W'(i + BASE_VEC);
          end
        end
      end
      ivau_pkg::ACT_FREE: begin
        if (in_range) begin
          vec_in_use[slot] = 1'b0;
          r.status = ivau_pkg::ST_OK;
        end
      end
      ivau_pkg::ACT_ROUTE: begin
        if (!in_range) begin
          r.status = ivau_pkg::ST_INVALID;
        end else if (handler_of[slot] != '0) begin
          r.status = ivau_pkg::ST_BUSY;
        end else begin
          vec_in_use[slot] = 1'b1;
          handler_of[slot] = c.handler;
          flags_of[slot] = c.flags;
          events_of[slot] = '0;
          r.status = ivau_pkg::ST_OK;
        end
      end
      ivau_pkg::ACT_UNROUTE: begin
        if (!in_range) begin
          r.status = ivau_pkg::ST_INVALID;
        end else begin
          handler_of[slot] = '0;
          r.status = ivau_pkg::ST_OK;
        end
      end
      ivau_pkg::ACT_RAISE: begin
        if (!in_range) begin
          r.status = ivau_pkg::ST_INVALID;
        end else if (handler_of[slot] != '0) begin
          events_of[slot] = events_of[slot] + ivau_pkg::DATA_W'(1);
          r.status = ivau_pkg::ST_OK;
          r.dispatch = 1'b1;
          r.handler = handler_of[slot];
          r.flags = flags_of[slot];
          r.events = events_of[slot];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic queue_cmd(input logic [2:0] action, input int vector,
                           input int handler, input logic [ivau_pkg::DATA_W-1:0] flags);
    vec_cmd_t c;
    c.action = action;
    c.vector = ivau_pkg::VEC_W'(vector);
    c.handler = ivau_pkg::HID_W'(handler);
    c.flags = flags;
    cmd_q.push_back(c);
    if (action <= ivau_pkg::ACT_RAISE) planned_cmds++;
  endtask

  function automatic int pick_vector();
    // Mostly in range, sometimes anywhere in the 8-bit space.
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(BASE_VEC, BASE_VEC + NUM_VEC - 1);
  endfunction

  function automatic int pick_handler();
    if ($urandom_range(0, 9) == 0) return 0;
    return $urandom_range(1, 65535);
  endfunction

  task automatic compare_field(input string name, input logic [ivau_pkg::DATA_W-1:0] want,
                               input logic [ivau_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: presents queued command beats, with random gaps outside a quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(resolve_action(cur_cmd));
        cmds_taken++;
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 &&
            !((cmds_taken < 150 || cmds_taken >= 250) && $urandom_range(0, 99) < 22)) begin
          cur_cmd = cmd_q.pop_front();
          in_action <= cur_cmd.action;
          in_vector <= cur_cmd.vector;
          in_handler_id <= cur_cmd.handler;
          in_route_flags <= cur_cmd.flags;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    vec_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result beat, status %0h vector %0h",
                 $time, out_status, out_vector_out);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (want.dispatch) dispatches_seen++;
        if (want.status == ivau_pkg::ST_NONE_FREE) full_allocs_seen++;
        compare_field("status", ivau_pkg::DATA_W'(want.status),
                      ivau_pkg::DATA_W'(out_status));
        compare_field("vector_out", ivau_pkg::DATA_W'(want.vector),
                      ivau_pkg::DATA_W'(out_vector_out));
        compare_field("dispatch", ivau_pkg::DATA_W'(want.dispatch),
                      ivau_pkg::DATA_W'(out_dispatch));
        compare_field("handler_out", ivau_pkg::DATA_W'(want.handler),
                      ivau_pkg::DATA_W'(out_handler_out));
        compare_field("flags_out", want.flags, out_flags_out);
        compare_field("event_count", want.events, out_event_count);
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int kind;
    int v;
    int n;
    logic full_done;
    full_done = 1'b0;
    vec_in_use = '0;
    for (int i = 0; i < NUM_VEC; i++) begin
      handler_of[i] = '0;
      flags_of[i] = '0;
      events_of[i] = '0;
    end

    // Directed: range edges, busy and unrouted cases, zero handler, reserved actions.
    queue_cmd(ivau_pkg::ACT_ALLOC, 0, 0, '0);
    queue_cmd(ivau_pkg::ACT_ALLOC, 0, 0, '0);
    queue_cmd(ivau_pkg::ACT_FREE, 0, 0, '0);
    queue_cmd(ivau_pkg::ACT_FREE, 255, 0, '0);
    queue_cmd(ivau_pkg::ACT_FREE, BASE_VEC + NUM_VEC, 0, '0);
    queue_cmd(ivau_pkg::ACT_FREE, 40, 0, '0);
    queue_cmd(ivau_pkg::ACT_FREE, 33, 0, '0);
    queue_cmd(ivau_pkg::ACT_ROUTE, BASE_VEC - 1, 16'hffff, 32'hffff_ffff);
    queue_cmd(ivau_pkg::ACT_ROUTE, BASE_VEC + NUM_VEC - 1, 16'hffff, 32'hffff_ffff);
    queue_cmd(ivau_pkg::ACT_ROUTE, BASE_VEC + NUM_VEC - 1, 16'h1234, 32'h0);
    queue_cmd(ivau_pkg::ACT_RAISE, BASE_VEC + NUM_VEC - 1, 0, '0);
    queue_cmd(ivau_pkg::ACT_RAISE, BASE_VEC + NUM_VEC - 1, 0, '0);
    queue_cmd(ivau_pkg::ACT_UNROUTE, BASE_VEC + NUM_VEC - 1, 0, '0);
    queue_cmd(ivau_pkg::ACT_RAISE, BASE_VEC + NUM_VEC - 1, 0, '0);
    queue_cmd(ivau_pkg::ACT_ROUTE, BASE_VEC + NUM_VEC - 1, 16'h0001, 32'h0);
    queue_cmd(ivau_pkg::ACT_RAISE, BASE_VEC + NUM_VEC - 1, 0, '0);
    queue_cmd(ivau_pkg::ACT_ROUTE, 50, 0, 32'haaaa_5555);
    queue_cmd(ivau_pkg::ACT_RAISE, 50, 0, '0);
    queue_cmd(ivau_pkg::ACT_ROUTE, 50, 16'h8000, 32'h5555_aaaa);
    queue_cmd(ivau_pkg::ACT_RAISE, 50, 0, '0);
    queue_cmd(ivau_pkg::ACT_UNROUTE, 200, 0, '0);
    queue_cmd(ivau_pkg::ACT_UNROUTE, BASE_VEC, 0, '0);
    queue_cmd(ivau_pkg::ACT_RAISE, 0, 0, '0);
    for (logic [3:0] a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++) begin
      queue_cmd(a[2:0], 64, 16'hffff, 32'hffff_ffff);
    end

    // Random: mostly route/raise lifecycles, plus allocation churn and noise.
    while (planned_cmds < RAND_BEATS + 25) begin
      kind = $urandom_range(0, 99);
      if (!full_done && planned_cmds > 200) begin
        // Exhaust the map, then release a scattering of vectors.
        full_done = 1'b1;
        for (int i = 0; i < NUM_VEC + 4; i++) queue_cmd(ivau_pkg::ACT_ALLOC, 0, 0, '0);
        for (int i = 0; i < 15; i++) queue_cmd(ivau_pkg::ACT_FREE, pick_vector(), 0, '0);
      end else if (kind < 45) begin
        v = pick_vector();
        queue_cmd(ivau_pkg::ACT_ROUTE, v, pick_handler(), $urandom());
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) queue_cmd(ivau_pkg::ACT_RAISE, v, 0, '0);
        if ($urandom_range(0, 1)) queue_cmd(ivau_pkg::ACT_UNROUTE, v, 0, '0);
        if ($urandom_range(0, 1)) queue_cmd(ivau_pkg::ACT_FREE, v, 0, '0);
        queue_cmd(ivau_pkg::ACT_RAISE, v, 0, '0);
      end else if (kind < 65) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) queue_cmd(ivau_pkg::ACT_ALLOC, 0, 0, '0);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) queue_cmd(ivau_pkg::ACT_FREE, pick_vector(), 0, '0);
      end else begin
        queue_cmd(3'($urandom_range(0, ACT_RESERVED_LAST)), $urandom_range(0, 255),
                  $urandom_range(0, 65535), $urandom());
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (cmd_q.size() != 0 || start || outcome_q.size() != 0);
    repeat (8) @(posedge clk);

    $display("Run covered %0d command beats and %0d result beats.", cmds_taken, results_seen);
    $display("Dispatches checked: %0d, allocations on a full map: %0d.",
             dispatches_seen, full_allocs_seen);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
